// File: sv/lcg_pkg.sv
package lcg_pkg;

    localparam int MAX_SUBSET   = 16;
    localparam int ELEMENT_BITS = 8;
    localparam int IDX_W        = $clog2(MAX_SUBSET);
    localparam int SET_W        = 8;
    localparam int SUBSET_W     = 5;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_BADCFG    = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_SIZE    = 2'd0,
        CFG_SUBSET_SIZE = 2'd1,
        CFG_WITH_REP    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_EMIT,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic    first_init;
        logic    scan_init;
        logic    scan_step;
        logic    pivot_init;
        logic    fill_step;
        logic    emit_init;
        logic    emit_step;
        logic    emit_status;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic bad_cfg;
        logic cfg_write;
        logic scan_hit;
        logic at_first;
        logic at_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: sv/lcg_datapath.sv
module lcg_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lcg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcg_pkg::SET_W-1:0]         cfg_data,
    input  lcg_pkg::dp_cmd_t                  cmd,
    output lcg_pkg::dp_stat_t                 stat,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [lcg_pkg::ELEMENT_BITS-1:0]  element,
    output logic [lcg_pkg::IDX_W-1:0]         position,
    output logic                              last_element,
    output logic [1:0]                        status
);

    logic [lcg_pkg::SET_W-1:0]        set_size_reg;
    logic [lcg_pkg::SUBSET_W-1:0]     subset_size_reg;
    logic                             with_rep_reg;

    logic [lcg_pkg::ELEMENT_BITS-1:0] comb_mem [lcg_pkg::MAX_SUBSET];

    logic [lcg_pkg::SUBSET_W-1:0]     cnt_reg, cnt_next;
    logic [lcg_pkg::ELEMENT_BITS-1:0] fill_reg, fill_next;

    logic                             out_valid_reg;
    logic [lcg_pkg::ELEMENT_BITS-1:0] element_reg;
    logic [lcg_pkg::IDX_W-1:0]        position_reg;
    logic                             last_reg;
    lcg_pkg::status_t                 status_reg;

    logic [lcg_pkg::ELEMENT_BITS-1:0] rd_data;
    logic [lcg_pkg::SET_W:0]          limit;
    logic                             at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg    <= lcg_pkg::SET_W'(1);
            subset_size_reg <= lcg_pkg::SUBSET_W'(1);
            with_rep_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcg_pkg::CFG_SET_SIZE:    set_size_reg    <= cfg_data;
                lcg_pkg::CFG_SUBSET_SIZE: subset_size_reg <= cfg_data[lcg_pkg::SUBSET_W-1:0];
                lcg_pkg::CFG_WITH_REP:    with_rep_reg    <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    assign rd_data = comb_mem[cnt_reg[lcg_pkg::IDX_W-1:0]];
    assign at_last = (cnt_reg == subset_size_reg - 1'b1);

    // Bound below which the scanned entry can still grow: n with repetition, else n shifted by distance to end
    assign limit = with_rep_reg ? {1'b0, set_size_reg}
                 : {1'b0, set_size_reg} - (lcg_pkg::SET_W+1)'(subset_size_reg)
                   + (lcg_pkg::SET_W+1)'(cnt_reg) + 1'b1;

    always_comb
    begin
        stat.bad_cfg   = (subset_size_reg == '0)
                      || ((lcg_pkg::SET_W)'(subset_size_reg) > set_size_reg)
                      || (int'(subset_size_reg) > lcg_pkg::MAX_SUBSET);
        stat.cfg_write = cfg_we && ((cfg_index == lcg_pkg::CFG_SET_SIZE)
                      || (cfg_index == lcg_pkg::CFG_SUBSET_SIZE)
                      || (cfg_index == lcg_pkg::CFG_WITH_REP));
        stat.scan_hit  = ((lcg_pkg::SET_W+1)'(rd_data) < limit);
        stat.at_first  = (cnt_reg == '0);
        stat.at_last   = at_last;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        priority if (cmd.first_init || cmd.emit_init)
            cnt_next = '0;
        else if (cmd.scan_init)
            cnt_next = subset_size_reg - 1'b1;
        else if (cmd.scan_step)
            cnt_next = cnt_reg - 1'b1;
        else if (cmd.fill_step || cmd.emit_step)
            cnt_next = cnt_reg + 1'b1;
        else
            cnt_next = cnt_reg;

        priority if (cmd.first_init)
            fill_next = lcg_pkg::ELEMENT_BITS'(1);
        else if (cmd.pivot_init)
            fill_next = rd_data + 1'b1;
        else if (cmd.fill_step && !with_rep_reg)
            fill_next = fill_reg + 1'b1;
        else
            fill_next = fill_reg;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        fill_reg <= fill_next;
        if (cmd.fill_step)
            comb_mem[cnt_reg[lcg_pkg::IDX_W-1:0]] <= fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_step || cmd.emit_status)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            element_reg  <= rd_data;
            position_reg <= cnt_reg[lcg_pkg::IDX_W-1:0];
            last_reg     <= at_last;
            status_reg   <= lcg_pkg::STATUS_OK;
        end
        else if (cmd.emit_status)
        begin
            element_reg  <= '0;
            position_reg <= '0;
            last_reg     <= 1'b1;
            status_reg   <= cmd.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign element      = element_reg;
    assign position     = position_reg;
    assign last_element = last_reg;
    assign status       = status_reg;

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != lcg_pkg::STATUS_OK) |-> (last_reg && element_reg == '0))
        else $error("status result not a single zero element");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_step || cmd.emit_status) |-> stat.out_free)
        else $error("result loaded over one still pending");

endmodule

// File: sv/lcg_ctrl.sv
module lcg_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    input  lcg_pkg::dp_stat_t  stat,
    output lcg_pkg::dp_cmd_t   cmd
);

    lcg_pkg::state_t  state_reg, state_next;
    logic             started_reg, started_next;
    logic             exhausted_reg, exhausted_next;
    lcg_pkg::status_t report_reg, report_next;
    logic             accept;

    assign in_stall = (state_reg != lcg_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcg_pkg::S_IDLE;
            started_reg   <= 1'b0;
            exhausted_reg <= 1'b0;
            report_reg    <= lcg_pkg::STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            exhausted_reg <= exhausted_next;
            report_reg    <= report_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        exhausted_next = exhausted_reg;
        report_next    = report_reg;
        cmd            = '0;
        cmd.status     = report_reg;

        unique case (state_reg)
            lcg_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    priority if (stat.bad_cfg)
                    begin
                        report_next = lcg_pkg::STATUS_BADCFG;
                        state_next  = lcg_pkg::S_REPORT;
                    end
                    else if (restart || !started_reg)
                    begin
                        cmd.first_init = 1'b1;
                        started_next   = 1'b1;
                        exhausted_next = 1'b0;
                        state_next     = lcg_pkg::S_FILL;
                    end
                    else if (exhausted_reg)
                    begin
                        report_next = lcg_pkg::STATUS_EXHAUSTED;
                        state_next  = lcg_pkg::S_REPORT;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = lcg_pkg::S_SCAN;
                    end
                end
            end
            lcg_pkg::S_SCAN:
            begin
                priority if (stat.scan_hit)
                begin
                    cmd.pivot_init = 1'b1;
                    state_next     = lcg_pkg::S_FILL;
                end
                else if (stat.at_first)
                begin
                    exhausted_next = 1'b1;
                    report_next    = lcg_pkg::STATUS_EXHAUSTED;
                    state_next     = lcg_pkg::S_REPORT;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            lcg_pkg::S_FILL:
            begin
                // write pivot and refill the tail, then rewind for output
                cmd.fill_step = 1'b1;
                if (stat.at_last)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = lcg_pkg::S_EMIT;
                end
            end
            lcg_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (stat.at_last)
                        state_next = lcg_pkg::S_IDLE;
                end
            end
            lcg_pkg::S_REPORT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = lcg_pkg::S_IDLE;
                end
            end
            default:
                state_next = lcg_pkg::S_IDLE;
        endcase

        // register writes drop the sequence position
        if (stat.cfg_write)
        begin
            started_next   = 1'b0;
            exhausted_next = 1'b0;
        end
    end

    a_exh_started: assert property (@(posedge clk) disable iff (!rst_n)
        exhausted_reg |-> started_reg)
        else $error("exhausted without a started sequence");

    a_badcfg_report: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stat.bad_cfg) |=>
            (state_reg == lcg_pkg::S_REPORT && report_reg == lcg_pkg::STATUS_BADCFG))
        else $error("bad configuration not reported");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcg_pkg::S_SCAN && !stat.scan_hit && stat.at_first && !stat.cfg_write)
            |=> (exhausted_reg && state_reg == lcg_pkg::S_REPORT))
        else $error("failed scan did not mark exhaustion");

endmodule

// File: sv/lex_combination_generator.sv
// Lexicographic k-combination generator over {1..n}, with or without repetition.
// Configuration: write set_size (index 0), subset_size (1), with_repetition (2)
// through cfg_we/cfg_index/cfg_data while idle; any valid write restarts the
// sequence at the first combination.
// Requests arrive on in_valid/in_stall with one bit, restart. Results leave on
// out_valid/out_stall: one per element (element, position, last_element set on
// the final one), or a single result with status exhausted or bad configuration.
// Sequencing (k = subset size, p = pivot position):
//   restart: fill all k entries, then one result per cycle while the output is free.
//   advance: scan from entry k-1 down to the pivot p, refill entries p..k-1, send k results.
//   status only: one status result, after a full scan when the scan runs off the front.
// The single-port combination store, one entry per cycle, forces this order.
// One request is worked at a time; the next is taken as soon as the last
// result is registered, while that result still waits on the output.
// A stalled output freezes result generation with the payload held.
// Reset: n = 1, k = 1, no repetition, not started, output empty.
module lex_combination_generator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lcg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcg_pkg::SET_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lcg_pkg::ELEMENT_BITS-1:0]  element,
    output logic [lcg_pkg::IDX_W-1:0]         position,
    output logic                              last_element,
    output logic [1:0]                        status
);

    lcg_pkg::dp_cmd_t  cmd;
    lcg_pkg::dp_stat_t stat;

    lcg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .restart  (restart),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcg_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .element      (element),
        .position     (position),
        .last_element (last_element),
        .status       (status)
    );

endmodule

// File: sim/lex_combination_generator_tb.sv
`timescale 1ns / 1ps

module lex_combination_generator_tb;

    localparam logic [lcg_pkg::CFG_IDX_W-1:0] CFG_RESERVED = 2'd3;
    localparam int RANDOM_REQUESTS = 380;
    localparam int DRAIN_CYCLES    = 3 * lcg_pkg::MAX_SUBSET + 4;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 3000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [lcg_pkg::ELEMENT_BITS-1:0] element;
        logic [lcg_pkg::IDX_W-1:0]        position;
        logic                             last_elem;
        lcg_pkg::status_t                 status;
    } comb_result_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [lcg_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [lcg_pkg::SET_W-1:0]        cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    logic                             restart   = 1'b0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [lcg_pkg::ELEMENT_BITS-1:0] element;
    logic [lcg_pkg::IDX_W-1:0]        position;
    logic                             last_element;
    logic [1:0]                       status;

    lex_combination_generator dut (.*);

    // combination generator state as seen from outside
    logic [lcg_pkg::SET_W-1:0]        gen_n   = 8'd1;
    logic [lcg_pkg::SUBSET_W-1:0]     gen_k   = 5'd1;
    logic                             gen_rep = 1'b0;
    logic [lcg_pkg::ELEMENT_BITS-1:0] gen_comb [lcg_pkg::MAX_SUBSET];
    bit                               gen_started = 1'b0;
    bit                               gen_done    = 1'b0;

    comb_result_t expected_elements [$];
    bit           pending_restarts [$];
    int           requests_queued   = 0;
    int           requests_taken    = 0;
    int           mismatches        = 0;
    int           quiet_cycles      = 0;
    bit           request_taken     = 1'b0;
    int           hold_off_requests = 0;
    int           hold_offs_done    = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void push_result(logic [lcg_pkg::ELEMENT_BITS-1:0] value, int idx,
                                        bit last_one, lcg_pkg::status_t st);
        comb_result_t r;
        r.element   = value;
        r.position  = lcg_pkg::IDX_W'(idx);
        r.last_elem = last_one;
        r.status    = st;
        expected_elements.push_back(r);
    endfunction

    // find the rightmost position that can still grow, bump it, refill the tail
    function automatic bit advance_combination();
        int p, j, lim;
        logic [lcg_pkg::ELEMENT_BITS-1:0] v;
        for (p = int'(gen_k) - 1; p >= 0; p--)
        begin
            lim = gen_rep ? int'(gen_n) : int'(gen_n) - int'(gen_k) + p + 1;
            if (int'(gen_comb[p]) < lim)
            begin
                v = gen_comb[p] + 1'b1;
                gen_comb[p] = v;
                for (j = p + 1; j < int'(gen_k); j++)
                    gen_comb[j] = gen_rep ? v : v + lcg_pkg::ELEMENT_BITS'(j - p);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_request(bit from_start);
        int i;
        if (gen_k == 0 || gen_k > gen_n || gen_k > lcg_pkg::MAX_SUBSET)
        begin
            push_result('0, 0, 1'b1, lcg_pkg::STATUS_BADCFG);
            return;
        end
        if (from_start || !gen_started)
        begin
            for (i = 0; i < int'(gen_k); i++)
                gen_comb[i] = gen_rep ? lcg_pkg::ELEMENT_BITS'(1)
                                      : lcg_pkg::ELEMENT_BITS'(i + 1);
            gen_started = 1'b1;
            gen_done    = 1'b0;
        end
        else if (gen_done || !advance_combination())
        begin
            gen_done = 1'b1;
            push_result('0, 0, 1'b1, lcg_pkg::STATUS_EXHAUSTED);
            return;
        end
        for (i = 0; i < int'(gen_k); i++)
            push_result(gen_comb[i], i, i + 1 == int'(gen_k), lcg_pkg::STATUS_OK);
    endfunction

    task automatic write_reg(logic [lcg_pkg::CFG_IDX_W-1:0] idx,
                             logic [lcg_pkg::SET_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx != CFG_RESERVED)
        begin
            case (idx)
                lcg_pkg::CFG_SET_SIZE:    gen_n   = data;
                lcg_pkg::CFG_SUBSET_SIZE: gen_k   = data[lcg_pkg::SUBSET_W-1:0];
                lcg_pkg::CFG_WITH_REP:    gen_rep = data[0];
                default:                  ;
            endcase
            gen_started = 1'b0;
            gen_done    = 1'b0;
        end
    endtask

    task automatic configure(logic [lcg_pkg::SET_W-1:0] n_data,
                             logic [lcg_pkg::SET_W-1:0] k_data,
                             logic [lcg_pkg::SET_W-1:0] rep_data);
        int first, i;
        first = $urandom_range(0, 2);
        for (i = 0; i < 3; i++)
        begin
            case ((first + i) % 3)
                0:       write_reg(lcg_pkg::CFG_SET_SIZE, n_data);
                1:       write_reg(lcg_pkg::CFG_SUBSET_SIZE, k_data);
                default: write_reg(lcg_pkg::CFG_WITH_REP, rep_data);
            endcase
        end
    endtask

    task automatic queue_request(bit from_start);
        pending_restarts.push_back(from_start);
        requests_queued++;
    endtask

    // wait until every request is taken and answered, then let the block settle
    task automatic drain();
        while (requests_taken != requests_queued || expected_elements.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(logic [lcg_pkg::SET_W-1:0] n_data,
                             logic [lcg_pkg::SET_W-1:0] k_data,
                             logic [lcg_pkg::SET_W-1:0] rep_data, int count, int restart_pct);
        configure(n_data, k_data, rep_data);
        repeat (count) queue_request($urandom_range(0, 99) < restart_pct);
        drain();
    endtask

    // request sender: bursts with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || request_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_restarts.size() != 0)
            begin
                in_valid <= 1'b1;
                restart  <= pending_restarts.pop_front();
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: stall pattern of its own, plus long hold-offs on demand
    int stall_pct = 0;
    int mode_left = 0;
    int hold_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_offs_done != hold_off_requests)
        begin
            hold_offs_done++;
            hold_left = HOLD_OFF_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        comb_result_t got, want;
        if (rst_n)
        begin
            request_taken = in_valid && !in_stall;
            // check before predicting: a result never belongs to a request taken at this edge
            if (out_valid && !out_stall)
            begin
                got = '{element, position, last_element, lcg_pkg::status_t'(status)};
                if (expected_elements.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: element %0d position %0d last %0b status %0d",
                                 got.element, got.position, got.last_elem, got.status);
                end
                else
                begin
                    want = expected_elements.pop_front();
                    if (got.element !== want.element || got.position !== want.position ||
                        got.last_elem !== want.last_elem || got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("result mismatch: expected element %0d position %0d last %0b status %0d",
                                     want.element, want.position, want.last_elem, want.status);
                            $display("                 got element %0d position %0d last %0b status %0d",
                                     got.element, got.position, got.last_elem, got.status);
                        end
                    end
                end
            end
            if (request_taken)
            begin
                predict_request(restart);
                requests_taken++;
            end
            if (request_taken || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int kind, n, k, count, pct, random_queued;
        logic [lcg_pkg::SET_W-1:0] rep_data;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: advance before any restart starts the sequence
        queue_request(1'b0);
        queue_request(1'b0);
        queue_request(1'b0);
        queue_request(1'b1);
        queue_request(1'b0);
        drain();

        // empty subset
        configure(8'd255, 8'd0, 8'd0);
        queue_request(1'b1);
        queue_request(1'b0);
        drain();
        // subset larger than the set
        configure(8'd1, 8'd2, 8'd0);
        queue_request(1'b0);
        drain();
        // subset beyond the store
        configure(8'd255, 8'd17, 8'd0);
        queue_request(1'b1);
        drain();
        // full-width subset with a single combination
        configure(8'd16, 8'hF0, 8'd0);
        queue_request(1'b0);
        queue_request(1'b0);
        queue_request(1'b1);
        drain();
        // repetition over two values, full width
        configure(8'd2, 8'hF0, 8'hFF);
        queue_request(1'b0);
        queue_request(1'b0);
        queue_request(1'b0);
        drain();
        // unused index leaves the sequence where it is
        write_reg(CFG_RESERVED, 8'hA5);
        queue_request(1'b0);
        drain();
        // any real write goes back to the first combination
        write_reg(lcg_pkg::CFG_WITH_REP, 8'h01);
        queue_request(1'b0);
        drain();

        random_queued = 0;
        // hold the output a long time while requests keep coming
        hold_off_requests++;
        run_phase(8'd18, 8'd16, 8'd0, 8, 10);
        random_queued += 8;
        // walk one element up past the top bit and off the end
        run_phase(8'd135, 8'd1, 8'($urandom_range(0, 255)), 136, 0);
        random_queued += 136;

        while (random_queued < RANDOM_REQUESTS)
        begin
            kind     = $urandom_range(0, 9);
            rep_data = 8'($urandom_range(0, 255));
            if (kind <= 4)
            begin
                n     = $urandom_range(1, 9);
                k     = $urandom_range(1, n < 6 ? n : 6);
                count = $urandom_range(8, 30);
                pct   = 5;
            end
            else if (kind == 5)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        n = $urandom_range(0, 255);
                        k = 0;
                    end
                    1:
                    begin
                        n = $urandom_range(0, 15);
                        k = $urandom_range(n + 1, 16);
                    end
                    default:
                    begin
                        n = 255;
                        k = $urandom_range(17, 31);
                    end
                endcase
                count = $urandom_range(2, 4);
                pct   = 50;
            end
            else if (kind == 6)
            begin
                n     = $urandom_range(16, 20);
                k     = 16;
                count = $urandom_range(4, 10);
                pct   = 10;
            end
            else if (kind == 7)
            begin
                n     = 255;
                k     = $urandom_range(1, 16);
                count = $urandom_range(5, 12);
                pct   = 20;
            end
            else
            begin
                n     = $urandom_range(6, 12);
                k     = $urandom_range(2, 5);
                count = $urandom_range(15, 40);
                pct   = 3;
            end
            run_phase(8'(n), 8'(k | ($urandom_range(0, 7) << 5)), rep_data, count, pct);
            random_queued += count;
        end

        drain();
        if (mismatches == 0 && expected_elements.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
